### rtl/core/mse_pkg.sv
// Package for the streaming MSE loss block: widths, codes and shared types.
// No dependencies; every other file of the block but mse_if imports it.
package mse_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ValueW = 48;
  localparam int unsigned CountW = 21;
  localparam int unsigned MaxElementsDefault = 1048576;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_MEAN = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ELEM = 2'd0,
    KIND_RED  = 2'd1,
    KIND_GRAD = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_OUT  = 2'd2
  } back_state_e;

  // One classified job from the front part to the back part.
  typedef struct packed {
    logic [ValueW-1:0] value;   // dividend, or final value when no division
    logic [CountW-1:0] divisor;
    logic              do_div;
    logic              neg;     // sign of value when dividing (magnitude held)
    logic [1:0]        kind;
    logic              end_flag;
  } job_t;

endpackage

### rtl/core/mse_if.sv
// Valid/ready channel interfaces for the MSE loss block.
// Its field widths are written out as literals; it does not import mse_pkg.
interface mse_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [15:0]        prediction;
  logic signed [15:0]        target;
  logic signed [15:0]        upstream;
  logic                      last;
  modport source (output valid, command, prediction, target, upstream, last, input ready);
  modport sink   (input valid, command, prediction, target, upstream, last, output ready);
endinterface

interface mse_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [47:0]        value;
  logic [1:0]                kind;
  logic                      end_flag;
  modport source (output valid, value, kind, end_flag, input ready);
  modport sink   (input valid, value, kind, end_flag, output ready);
endinterface

### rtl/core/mse_front.sv
// Front part: accepts items, keeps the accumulator and counters, and
// classifies each item into a job for the back part. Depends on mse_pkg.
module mse_front #(
  parameter int unsigned MaxElements = mse_pkg::MaxElementsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  mse_in_if.sink              in_if,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output mse_pkg::job_t       job_o
);
  import mse_pkg::*;

  localparam logic [CountW-1:0] CountCap =
    (MaxElements < (2**CountW - 1)) ? CountW'(MaxElements) : {CountW{1'b1}};
  localparam logic [ValueW-1:0] AccMax = {1'b0, {(ValueW-1){1'b1}}};

  // Stage 1 registers the difference and the upstream value; stage 2 forms
  // the products and builds the job.
  logic [1:0]        mode_q;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d, saved_q, saved_d;

  logic              s1_valid_q;
  logic              s1_cmd_q, s1_last_q;
  logic signed [16:0] s1_diff_q;
  logic signed [15:0] s1_up_q;

  logic              s2_valid_q;
  job_t              s2_job_q, s2_job_d;
  logic              s2_emit_d;

  logic signed [33:0] sq;
  logic signed [34:0] grad;
  logic [ValueW-1:0]  acc_sum;
  logic [ValueW-1:0]  gmag;
  logic               adv;

  // Stage 2 holds its job until the queue takes it; stage 1 waits behind it.
  assign adv          = !s2_valid_q || job_ready_i;
  assign in_if.ready  = adv;
  assign job_valid_o  = s2_valid_q;
  assign job_o        = s2_job_q;

  assign sq   = s1_diff_q * s1_diff_q;
  assign grad = (35'(s1_diff_q) * 35'(s1_up_q)) <<< 1;
  assign gmag = grad[34] ? ValueW'(-grad) : ValueW'(grad);
  assign acc_sum = acc_q + ValueW'(sq);

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    saved_d   = saved_q;
    s2_emit_d = 1'b0;
    s2_job_d  = '0;
    s2_job_d.end_flag = s1_last_q;
    if (s1_cmd_q) begin
      s2_emit_d     = 1'b1;
      s2_job_d.kind = KIND_GRAD;
      if (mode_q == MODE_MEAN) begin
        s2_job_d.do_div  = (saved_q != '0);
        s2_job_d.value   = (saved_q != '0) ? gmag : '0;
        s2_job_d.neg     = grad[34];
        s2_job_d.divisor = saved_q;
      end else begin
        s2_job_d.value = ValueW'(grad);
      end
    end else begin
      if (cnt_q < CountCap) cnt_d = cnt_q + 1'b1;
      if (mode_q == MODE_NONE) begin
        s2_emit_d      = 1'b1;
        s2_job_d.kind  = KIND_ELEM;
        s2_job_d.value = ValueW'(sq);
      end else begin
        acc_d = (ValueW'(sq) > AccMax - acc_q) ? AccMax : acc_sum;
      end
      if (s1_last_q) begin
        saved_d = cnt_d;
        if (mode_q != MODE_NONE) begin
          s2_emit_d        = 1'b1;
          s2_job_d.kind    = KIND_RED;
          s2_job_d.value   = acc_d;
          s2_job_d.do_div  = (mode_q == MODE_MEAN);
          s2_job_d.divisor = cnt_d;
        end
        acc_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_MEAN;
      acc_q      <= '0;
      cnt_q      <= '0;
      saved_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (adv) begin
        s1_valid_q <= in_if.valid;
        s2_valid_q <= s1_valid_q && s2_emit_d;
        if (s1_valid_q) begin
          acc_q   <= acc_d;
          cnt_q   <= cnt_d;
          saved_q <= saved_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= in_if.command;
      s1_last_q <= in_if.last;
      s1_diff_q <= 17'(in_if.prediction) - 17'(in_if.target);
      s1_up_q   <= in_if.upstream;
      s2_job_q  <= s2_job_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !acc_q[ValueW-1])
    else $error("accumulator went negative");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CountCap)
    else $error("element counter above cap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_job_q.do_div |-> s2_job_q.divisor != '0)
    else $error("division job with zero divisor");
endmodule

### rtl/core/mse_queue.sv
// Short two-entry queue between front and back parts.
// Depends on mse_pkg for the job type.
module mse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  mse_pkg::job_t wr_job_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output mse_pkg::job_t rd_job_o
);
  import mse_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  logic       wr, rd;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_job_o   = mem_q[rptr_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (wr) wptr_q <= !wptr_q;
      if (rd) rptr_q <= !rptr_q;
      fill_q <= fill_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_job_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> fill_q == $past(fill_q) + 2'd1)
    else $error("queue fill did not grow on write");
endmodule

### rtl/core/mse_back.sv
// Back part: carries out a job, running a restoring divider one quotient
// bit per cycle when needed, and holds the result. Depends on mse_pkg.
module mse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  mse_pkg::job_t job_i,
  mse_out_if.source     out_if
);
  import mse_pkg::*;

  localparam int unsigned StepW = $clog2(ValueW + 1);

  back_state_e state_q, state_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [CountW-1:0] div_q;
  logic [StepW-1:0]  step_q, step_d;
  logic              neg_q;
  logic [ValueW-1:0] val_q, val_d;
  logic [1:0]        kind_q;
  logic              end_q;
  logic [CountW:0]   trial;
  logic              load;

  assign out_if.valid    = (state_q == ST_OUT);
  assign out_if.value    = val_q;
  assign out_if.kind     = kind_q;
  assign out_if.end_flag = end_q;
  assign trial = {rem_q[CountW-1:0], quo_q[ValueW-1]};

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    val_d       = val_q;
    job_ready_o = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          load = 1'b1;
          if (job_i.do_div) begin
            quo_d   = job_i.value;
            rem_d   = '0;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            val_d   = job_i.value;
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial - {1'b0, div_q};
          quo_d = {quo_q[ValueW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[ValueW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ValueW - 1)) begin
          val_d   = neg_q ? -quo_d : quo_d;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_if.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    val_q  <= val_d;
    if (load) begin
      div_q  <= job_i.divisor;
      neg_q  <= job_i.neg;
      kind_q <= job_i.kind;
      end_q  <= job_i.end_flag;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && !out_if.ready |=> state_q == ST_OUT && $stable(val_q))
    else $error("held result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != '0)
    else $error("divider running with zero divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {1'b0, div_q})
    else $error("remainder not below divisor");
endmodule

### rtl/core/mse_loss_with_gradient.sv
// Top level of the streaming MSE loss and gradient block.
// Depends on mse_pkg, mse_if, mse_front, mse_queue and mse_back.
//
//  channel | dir | handshake      | payload
//  in_if   | in  | valid/ready    | command, prediction, target, upstream, last
//  out_if  | out | valid/ready    | value, kind, end_flag
//  cfg     | in  | cfg_we_i only  | cfg_wdata_i = reduction_mode
//
// The front accepts one item per cycle while the queue has room. A result
// without division passes through two front stages, the queue, and the
// back's output register; the back takes a new job only once its last
// result has been taken. A mean-mode result (reduced loss or gradient) also
// passes through the bit-serial divider of the back part.
// The two-entry queue lets the front keep accepting while the back divides.
// Reset clears the mode to mean, accumulator, counters and all valid flags.
module mse_loss_with_gradient #(
  parameter int unsigned MaxElements = mse_pkg::MaxElementsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  mse_in_if.sink     in_if,
  mse_out_if.source  out_if
);
  import mse_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  mse_front #(.MaxElements(MaxElements)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_if,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  mse_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_job_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_job_o(b_job)
  );

  mse_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job), .out_if
  );
endmodule
